FILE: rtl/core/dsms_pkg.sv
package dsms_pkg;

  // Field widths of the item and result beats
  localparam int unsigned AMOUNT_W  = 16;
  localparam int unsigned MOTION_W  = 2;
  localparam int unsigned COILS_W   = 4;
  localparam int unsigned QUEUED_W  = 5;
  localparam int unsigned STEPS_W   = 16;
  localparam int unsigned HP_W      = 8;
  localparam int unsigned RATE_W    = 8;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  // Turn amount, in degrees, that takes the programmed right-angle count
  localparam logic [AMOUNT_W-1:0] RIGHT_ANGLE_DEG = AMOUNT_W'(90);

  // Item opcodes
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_ENQUEUE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS_MM    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS_DEG   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_ANGLE = 2'd3;

  typedef enum logic [MOTION_W-1:0] {
    MOTION_FWD   = 2'd0,
    MOTION_BWD   = 2'd1,
    MOTION_LEFT  = 2'd2,
    MOTION_RIGHT = 2'd3
  } motion_e;

  typedef struct packed {
    logic                op;
    logic [MOTION_W-1:0] motion;
    logic [AMOUNT_W-1:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [COILS_W-1:0]  left_coils;
    logic [COILS_W-1:0]  right_coils;
    logic                busy_res;
    logic [QUEUED_W-1:0] queued;
    logic                dropped;
  } res_item_t;

  // One queued command
  typedef struct packed {
    logic [MOTION_W-1:0] motion;
    logic [AMOUNT_W-1:0] amount;
  } cmd_t;

  typedef struct packed {
    logic [HP_W-1:0]    half_period;
    logic [RATE_W-1:0]  steps_per_mm;
    logic [RATE_W-1:0]  steps_per_degree;
    logic [STEPS_W-1:0] right_angle_steps;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    half_period:       HP_W'(2),
    steps_per_mm:      RATE_W'(1),
    steps_per_degree:  RATE_W'(1),
    right_angle_steps: STEPS_W'(90)
  };

  // Coil drive status handed from the sequencer to the result path
  typedef struct packed {
    logic [COILS_W-1:0] left_coils;
    logic [COILS_W-1:0] right_coils;
    logic               busy;
  } seq_status_t;

endpackage

FILE: rtl/core/dsms_stream_if.sv
interface dsms_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/dsms_cmd_fifo.sv
module dsms_cmd_fifo
  import dsms_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF,
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  cmd_t             push_data_i,
  input  logic             pop_i,
  output cmd_t             head_o,
  output logic             head_valid_o,
  output logic             full_o,
  output logic [CNT_W-1:0] count_next_o
);

  cmd_t             mem_q [DEPTH];
  cmd_t             head_q;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full_o       = (count_q == CNT_W'(DEPTH));
  assign head_valid_o = (count_q != '0);
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? next_slot(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop  ? next_slot(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  assign count_next_o = count_d;
  assign head_o       = head_q;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Head holds the oldest entry: write through when empty, read ahead on pop
  always_ff @(posedge clk_i) begin
    if (do_push && !head_valid_o) begin
      head_q <= push_data_i;
    end else if (do_pop) begin
      head_q <= mem_q[rd_ptr_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("command queue count above depth");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == CNT_W'(DEPTH)) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");
`endif

endmodule

FILE: rtl/core/dsms_sequencer.sv
module dsms_sequencer
  import dsms_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        tick_i,
  input  cfg_t        cfg_i,
  input  cmd_t        head_i,
  input  logic        head_valid_i,
  output logic        pop_o,
  output seq_status_t status_o
);

  logic [MOTION_W-1:0] motion_q, motion_d;
  logic [STEPS_W-1:0]  steps_q, steps_d;
  logic [1:0]          coil_q, coil_d;
  logic                high_q, high_d;
  logic [HP_W-1:0]     tick_q, tick_d;
  logic                running_q, running_d;

  logic [RATE_W-1:0]          rate;
  logic [AMOUNT_W+RATE_W-1:0] product;
  logic [STEPS_W-1:0]         prod16, turn_n, step_n;
  logic                       phase_end;
  logic [1:0]                 li, ri;

  // Step count of the head command
  always_comb begin
    rate    = head_i.motion[1] ? cfg_i.steps_per_degree : cfg_i.steps_per_mm;
    product = head_i.amount * rate;
    prod16  = product[STEPS_W-1:0];
    turn_n  = (head_i.amount == RIGHT_ANGLE_DEG) ? cfg_i.right_angle_steps : prod16;
    step_n  = head_i.motion[1] ? (turn_n >> 1) : prod16;
  end

  // A zero half period ends every phase at once, same as one
  assign phase_end = ({1'b0, tick_q} + (HP_W + 1)'(1)) >= {1'b0, cfg_i.half_period};

  always_comb begin
    motion_d  = motion_q;
    steps_d   = steps_q;
    coil_d    = coil_q;
    high_d    = high_q;
    tick_d    = tick_q;
    running_d = running_q;
    pop_o     = 1'b0;
    if (tick_i) begin
      if (running_q) begin
        if (phase_end) begin
          tick_d = '0;
          if (high_q) begin
            high_d = 1'b0;
          end else begin
            steps_d = steps_q - STEPS_W'(1);
            coil_d  = coil_q + 2'd1;
            if (steps_q == STEPS_W'(1)) begin
              running_d = 1'b0;
            end else begin
              high_d = 1'b1;
            end
          end
        end else begin
          tick_d = tick_q + HP_W'(1);
        end
      end else if (head_valid_i) begin
        pop_o    = 1'b1;
        motion_d = head_i.motion;
        if (step_n != '0) begin
          steps_d   = step_n;
          running_d = 1'b1;
          high_d    = 1'b1;
          tick_d    = '0;
          coil_d    = '0;
        end
      end
    end
  end

  // Coil order per direction, taken from the updated state
  always_comb begin
    unique case (motion_e'(motion_d))
      MOTION_FWD: begin
        li = coil_d;
        ri = coil_d;
      end
      MOTION_BWD: begin
        li = ~coil_d;
        ri = ~coil_d;
      end
      MOTION_LEFT: begin
        li = ~coil_d;
        ri = coil_d;
      end
      default: begin
        li = coil_d;
        ri = ~coil_d;
      end
    endcase
    status_o.busy        = running_d;
    status_o.left_coils  = '0;
    status_o.right_coils = '0;
    if (running_d && high_d) begin
      status_o.left_coils  = COILS_W'(1) << li;
      status_o.right_coils = COILS_W'(1) << ri;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motion_q  <= '0;
      steps_q   <= '0;
      coil_q    <= '0;
      high_q    <= 1'b0;
      tick_q    <= '0;
      running_q <= 1'b0;
    end else begin
      motion_q  <= motion_d;
      steps_q   <= steps_d;
      coil_q    <= coil_d;
      high_q    <= high_d;
      tick_q    <= tick_d;
      running_q <= running_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !running_q |-> (!high_q && tick_q == '0))
    else $error("idle sequencer holds phase state");

  a_run_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |-> (steps_q != '0))
    else $error("running with no steps left");

  a_start_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(running_q) |-> (high_q && coil_q == '0 && $past(pop_o)))
    else $error("command started without a pop or in the wrong phase");
`endif

endmodule

FILE: rtl/core/dsms_res_buf.sv
module dsms_res_buf
  import dsms_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  res_item_t push_data_i,
  output logic      space_o,
  output logic      valid_o,
  output res_item_t data_o,
  input  logic      ready_i
);

  res_item_t  slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_pop;

  assign space_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = slot_q[rd_q];
  assign do_pop  = valid_o && ready_i;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

FILE: rtl/core/dual_stepper_motion_sequencer.sv
// Channel  Dir  Beat payload                                      Accepted when
// in_i     in   op, motion, amount                                valid && ready
// out_o    out  left_coils, right_coils, busy_res, queued, dropped valid && ready
// cfg      in   cfg_idx_i, cfg_wdata_i                            cfg_we_i
//
// One input beat per cycle while a result slot is free; its result beat is available the next cycle.
// The command queue and the step sequencer both update in the cycle a beat
// is accepted; a two-entry result buffer lets input run while results wait.
// Input ready drops only when both result slots are occupied.
// Reset clears all control state; queue contents are not cleared.
module dual_stepper_motion_sequencer
  import dsms_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  dsms_stream_if.sink          in_i,
  dsms_stream_if.source        out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  in_item_t         item;
  cfg_t             cfg_q;
  logic             fire, tick, enq;
  logic             space;
  cmd_t             enq_cmd, head;
  logic             head_valid, full, pop;
  logic [CNT_W-1:0] count_next;
  seq_status_t      status;
  res_item_t        res, res_out;

  assign item = in_i.payload;

  // Classify the accepted beat: tick advances time, enqueue feeds the queue
  assign in_i.ready = space;
  assign fire       = in_i.valid && space;
  assign tick       = fire && (item.op == OP_TICK);
  assign enq        = fire && (item.op == OP_ENQUEUE);

  assign enq_cmd.motion = item.motion;
  assign enq_cmd.amount = item.amount;

  // Configuration registers; writes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_HALF_PERIOD: cfg_q.half_period       <= cfg_wdata_i[HP_W-1:0];
        REG_STEPS_MM:    cfg_q.steps_per_mm      <= cfg_wdata_i[RATE_W-1:0];
        REG_STEPS_DEG:   cfg_q.steps_per_degree  <= cfg_wdata_i[RATE_W-1:0];
        REG_RIGHT_ANGLE: cfg_q.right_angle_steps <= cfg_wdata_i[STEPS_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: command queue with a read-ahead head register
  dsms_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (enq),
    .push_data_i  (enq_cmd),
    .pop_i        (pop),
    .head_o       (head),
    .head_valid_o (head_valid),
    .full_o       (full),
    .count_next_o (count_next)
  );

  // Back: step timing and coil drive
  dsms_sequencer u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (tick),
    .cfg_i        (cfg_q),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .status_o     (status)
  );

  // Assemble the result beat from the updated state
  always_comb begin
    res.left_coils  = status.left_coils;
    res.right_coils = status.right_coils;
    res.busy_res    = status.busy;
    res.queued      = QUEUED_W'(count_next);
    res.dropped     = enq && full;
  end

  dsms_res_buf u_res (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire),
    .push_data_i (res),
    .space_o     (space),
    .valid_o     (out_o.valid),
    .data_o      (res_out),
    .ready_i     (out_o.ready)
  );

  assign out_o.payload = res_out;

endmodule
